[rtl/dht_pulse_frame_decoder_defines.svh]
// assertion macros used by the checker
`ifndef DHT_PULSE_FRAME_DECODER_DEFINES_SVH
`define DHT_PULSE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define DHTPFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define DHTPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[rtl/dhtpfd_pkg.sv]
package dhtpfd_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_EDGE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CSUM    = 2'd1,
        STATUS_TIMEOUT = 2'd2
    } t_status;

    localparam int unsigned PADDR_W = 4;

    localparam logic [1:0] REG_SENSOR_TYPE = 2'd0;
    localparam logic [1:0] REG_LONG_THRESH = 2'd1;
    localparam logic [1:0] REG_TIMEOUT     = 2'd2;

    localparam logic        RST_SENSOR_TYPE = 1'b1;
    localparam logic [15:0] RST_LONG_THRESH = 16'd90;
    localparam logic [15:0] RST_TIMEOUT     = 16'd255;

    localparam logic [5:0] FRAME_PULSES = 6'd41;

endpackage

[rtl/dhtpfd_if.sv]
interface dhtpfd_in_if import dhtpfd_pkg::*; ();
    logic        valid;
    logic        ready;
    t_op         operation;
    logic [15:0] pulse_length;

    modport source (output valid, output operation, output pulse_length, input ready);
    modport sink   (input valid, input operation, input pulse_length, output ready);
endinterface

interface dhtpfd_out_if import dhtpfd_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic        [15:0] humidity;
    logic signed [15:0] temperature;

    modport source (output valid, output status, output humidity, output temperature,
                    input ready);
    modport sink   (input valid, input status, input humidity, input temperature,
                    output ready);
endinterface

[rtl/dht_pulse_frame_decoder.sv]
// an input beat is held in the input register, then decoded into the result register
// throughput: one input beat per cycle unless the output stalls; then one more beat gets in
// timing is set by the input register feeding the decode stage and the result register
// reset (i_rst_n low, synchronous): decoder disarmed, bit count cleared, pipeline emptied,
// registers back to sensor type 1, threshold 90, timeout 255
module dht_pulse_frame_decoder import dhtpfd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dhtpfd_in_if.sink          i_in,
    dhtpfd_out_if.source       o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_sensor_type;
    logic [15:0] r_long_thresh;
    logic [15:0] r_timeout;

    logic        r_in_valid;
    t_op         r_in_op;
    logic [15:0] r_in_len;

    logic        r_armed,     n_armed;
    logic [5:0]  r_bit_count, n_bit_count;
    logic [39:0] r_frame,     n_frame;

    logic               r_out_valid;
    t_status            r_out_status,  n_out_status;
    logic        [15:0] r_out_hum,     n_out_hum;
    logic signed [15:0] r_out_temp,    n_out_temp;
    logic               n_emit;

    logic        s2_go;
    logic        bit_val;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  csum;
    logic [15:0] hum, mag;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_type <= RST_SENSOR_TYPE;
            r_long_thresh <= RST_LONG_THRESH;
            r_timeout     <= RST_TIMEOUT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_SENSOR_TYPE: r_sensor_type <= pwdata[0];
                REG_LONG_THRESH: r_long_thresh <= pwdata[15:0];
                REG_TIMEOUT:     r_timeout     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SENSOR_TYPE: prdata = {31'd0, r_sensor_type};
            REG_LONG_THRESH: prdata = {16'd0, r_long_thresh};
            REG_TIMEOUT:     prdata = {16'd0, r_timeout};
            default:         prdata = 32'd0;
        endcase
    end

    // input register
    assign s2_go      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || s2_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op  <= i_in.operation;
            r_in_len <= i_in.pulse_length;
        end
    end

    // decode stage
    assign bit_val = (r_in_len >= r_long_thresh);

    assign b0   = n_frame[39:32];
    assign b1   = n_frame[31:24];
    assign b2   = n_frame[23:16];
    assign b3   = n_frame[15:8];
    assign b4   = n_frame[7:0];
    assign csum = b0 + b1 + b2 + b3;

    always_comb begin
        if (r_sensor_type) begin
            hum = {b0, b1};
            mag = {1'b0, b2[6:0], b3};
        end else begin
            hum = {5'd0, b0, 3'd0} + {7'd0, b0, 1'b0};
            mag = {6'd0, b2[6:0], 3'd0} + {8'd0, b2[6:0], 1'b0};
        end
    end

    always_comb begin
        n_armed      = r_armed;
        n_bit_count  = r_bit_count;
        n_frame      = r_frame;
        n_emit       = 1'b0;
        n_out_status = STATUS_OK;
        n_out_hum    = 16'd0;
        n_out_temp   = 16'sd0;
        unique case (r_in_op)
            OP_START: begin
                n_armed     = 1'b1;
                n_bit_count = 6'd0;
            end
            OP_EDGE: begin
                if (r_armed) begin
                    if (r_in_len > r_timeout) begin
                        n_armed      = 1'b0;
                        n_emit       = 1'b1;
                        n_out_status = STATUS_TIMEOUT;
                    end else begin
                        // sync pulse skipped
                        if (r_bit_count != 6'd0 && r_bit_count < FRAME_PULSES) begin
                            n_frame = {r_frame[38:0], bit_val};
                        end
                        n_bit_count = r_bit_count + 6'd1;
                        if (n_bit_count == FRAME_PULSES) begin
                            n_armed = 1'b0;
                            n_emit  = 1'b1;
                            if (csum != b4) begin
                                n_out_status = STATUS_CSUM;
                            end else begin
                                n_out_hum  = hum;
                                n_out_temp = b2[7] ? -$signed(mag) : $signed(mag);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_bit_count <= 6'd0;
        end else if (s2_go) begin
            r_armed     <= n_armed;
            r_bit_count <= n_bit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_frame <= n_frame;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go) begin
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && n_emit) begin
            r_out_status <= n_out_status;
            r_out_hum    <= n_out_hum;
            r_out_temp   <= n_out_temp;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.humidity    = r_out_hum;
    assign o_out.temperature = r_out_temp;

endmodule

[rtl/dhtpfd_checker.sv]
`include "dht_pulse_frame_decoder_defines.svh"

module dhtpfd_checker import dhtpfd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input t_status            i_out_status,
    input logic        [15:0] i_out_humidity,
    input logic signed [15:0] i_out_temperature
);

    logic        out_stall;
    logic        out_err;
    logic [33:0] out_beat;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_err   = i_out_valid && i_out_status != STATUS_OK;
    assign out_beat  = {i_out_status, i_out_humidity, i_out_temperature};

    // a stalled result beat holds
    `DHTPFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_beat))

    // error results carry no measurement
    `DHTPFD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, out_err, out_beat[31:0] == 32'd0)

    // input never blocked while the result slot is empty
    `DHTPFD_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // input blocked only by a stalled result
    `DHTPFD_ASSERT_NOW(a_block_cause, i_clk, i_rst_n, !i_in_ready, out_stall)

endmodule

bind dht_pulse_frame_decoder dhtpfd_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_humidity    (o_out.humidity),
    .i_out_temperature (o_out.temperature)
);

[tb/tb_dht_pulse_frame_decoder.sv]
typedef struct packed {
    dhtpfd_pkg::t_status status;
    logic        [15:0]  humidity;
    logic signed [15:0]  temperature;
} t_reading;

class dht_frame_scoreboard;
    bit          dht22_fmt;
    logic [15:0] long_thresh;
    logic [15:0] timeout_lim;
    logic [5:0]  pulse_cnt;
    logic [7:0]  rx_bytes [5];
    bit          armed;
    t_reading    pending_readings [$];
    int          fails;

    function new();
        dht22_fmt   = dhtpfd_pkg::RST_SENSOR_TYPE;
        long_thresh = dhtpfd_pkg::RST_LONG_THRESH;
        timeout_lim = dhtpfd_pkg::RST_TIMEOUT;
        pulse_cnt   = '0;
        armed       = 1'b0;
        foreach (rx_bytes[k]) rx_bytes[k] = '0;
        fails       = 0;
    endfunction

    function void flag(string msg);
        fails++;
        if (fails <= 10) $display("%s", msg);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            dhtpfd_pkg::REG_SENSOR_TYPE: dht22_fmt   = val[0];
            dhtpfd_pkg::REG_LONG_THRESH: long_thresh = val[15:0];
            dhtpfd_pkg::REG_TIMEOUT:     timeout_lim = val[15:0];
            default: ;
        endcase
    endfunction

    function t_reading decode_frame();
        t_reading    r;
        logic [7:0]  sum;
        logic [15:0] mag;
        sum           = rx_bytes[0] + rx_bytes[1] + rx_bytes[2] + rx_bytes[3];
        r.status      = dhtpfd_pkg::STATUS_CSUM;
        r.humidity    = '0;
        r.temperature = '0;
        if (sum != rx_bytes[4]) return r;
        r.status = dhtpfd_pkg::STATUS_OK;
        if (dht22_fmt) begin
            r.humidity = {rx_bytes[0], rx_bytes[1]};
            mag        = {1'b0, rx_bytes[2][6:0], rx_bytes[3]};
        end else begin
            r.humidity = 16'(rx_bytes[0]) * 16'd10;
            mag        = 16'(rx_bytes[2][6:0]) * 16'd10;
        end
        r.temperature = rx_bytes[2][7] ? -mag : mag;
        return r;
    endfunction

    function void note_pulse_beat(dhtpfd_pkg::t_op op, logic [15:0] len);
        int unsigned slot;
        t_reading    r;
        if (op == dhtpfd_pkg::OP_START) begin
            armed     = 1'b1;
            pulse_cnt = '0;
            return;
        end
        if (!armed) return;
        if (len > timeout_lim) begin
            armed         = 1'b0;
            r.status      = dhtpfd_pkg::STATUS_TIMEOUT;
            r.humidity    = '0;
            r.temperature = '0;
            pending_readings.push_back(r);
            return;
        end
        if (pulse_cnt >= 1 && pulse_cnt < dhtpfd_pkg::FRAME_PULSES) begin
            slot = (pulse_cnt - 1) >> 3;
            rx_bytes[slot] = {rx_bytes[slot][6:0], len >= long_thresh};
        end
        pulse_cnt++;
        if (pulse_cnt == dhtpfd_pkg::FRAME_PULSES) begin
            armed = 1'b0;
            pending_readings.push_back(decode_frame());
        end
    endfunction

    function void check_reading(dhtpfd_pkg::t_status st, logic [15:0] hum,
                                logic signed [15:0] temp);
        t_reading exp_r;
        if (pending_readings.size() == 0) begin
            flag($sformatf("unexpected reading: status %0d hum %0d temp %0d",
                           st, hum, temp));
            return;
        end
        exp_r = pending_readings.pop_front();
        if (st !== exp_r.status || hum !== exp_r.humidity || temp !== exp_r.temperature)
            flag({$sformatf("reading mismatch: exp status %0d hum %0d temp %0d",
                            exp_r.status, exp_r.humidity, exp_r.temperature),
                  $sformatf(", got status %0d hum %0d temp %0d", st, hum, temp)});
    endfunction

    function void close();
        if (pending_readings.size() != 0)
            flag($sformatf("%0d readings never arrived", pending_readings.size()));
    endfunction
endclass

module tb_dht_pulse_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import dhtpfd_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    dhtpfd_in_if  in_bus ();
    dhtpfd_out_if out_bus ();

    dht_frame_scoreboard sb = new();

    int tx_gap_max   = 12;
    int rx_stall_max = 12;
    int rx_hold      = 0;
    int useful_beats = 0;

    dht_pulse_frame_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                sb.note_pulse_beat(in_bus.operation, in_bus.pulse_length);
            if (out_bus.valid && out_bus.ready)
                sb.check_reading(out_bus.status, out_bus.humidity, out_bus.temperature);
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall;
        out_bus.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_bus.ready = 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end
            stall = $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                out_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready = 1'b1;
            do @(posedge i_clk); while (!out_bus.valid && rx_hold == 0);
            @(negedge i_clk);
        end
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_beat(t_op op, logic [15:0] len);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (op == OP_START || sb.armed) useful_beats++;
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid        = 1'b1;
        in_bus.operation    = op;
        in_bus.pulse_length = len;
        do @(posedge i_clk); while (!in_bus.ready);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic quiesce();
        in_bus.valid = 1'b0;
        while (sb.pending_readings.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(bit dht22, int thr, int tmo);
        quiesce();
        apb_write(REG_SENSOR_TYPE, 32'(dht22));
        apb_write(REG_LONG_THRESH, 32'(thr));
        apb_write(REG_TIMEOUT, 32'(tmo));
    endtask

    function automatic logic [39:0] with_sum(logic [31:0] payload);
        logic [7:0] cs;
        cs = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
        return {payload, cs};
    endfunction

    // bit time within the current threshold and timeout where possible
    function automatic logic [15:0] pulse_for(bit one);
        int thr;
        int tmo;
        thr = sb.long_thresh;
        tmo = sb.timeout_lim;
        if (one && thr <= tmo) return 16'($urandom_range(thr, tmo));
        if (!one && thr > 0) return 16'($urandom_range(0, (thr - 1 < tmo) ? thr - 1 : tmo));
        return 16'($urandom_range(0, tmo));
    endfunction

    function automatic logic [15:0] overlong_pulse();
        int tmo;
        tmo = sb.timeout_lim;
        if (tmo < 65535) return 16'($urandom_range(tmo + 1, 65535));
        return 16'hFFFF;
    endfunction

    // start, sync, then data bits msb first; optional abort by an over-long pulse
    task automatic send_frame(logic [39:0] data, int n_pulses, int abort_at);
        send_beat(OP_START, 16'($urandom));
        for (int i = 0; i < n_pulses; i++) begin
            if (i == abort_at) begin
                send_beat(OP_EDGE, overlong_pulse());
                return;
            end
            if (i == 0) send_beat(OP_EDGE, 16'($urandom_range(0, sb.timeout_lim)));
            else send_beat(OP_EDGE, pulse_for(data[40 - i]));
        end
    endtask

    function automatic logic [39:0] random_frame();
        logic [31:0] payload;
        logic [39:0] data;
        payload = $urandom;
        if ($urandom_range(0, 9) == 0) payload[15:0] = 16'h8000;
        data = with_sum(payload);
        if ($urandom_range(0, 7) == 0) data[7:0] = data[7:0] ^ (8'd1 << $urandom_range(0, 7));
        return data;
    endfunction

    task automatic random_frames(int n);
        int target;
        int pick;
        target = useful_beats + n;
        while (useful_beats < target) begin
            tx_gap_max   = ($urandom_range(0, 4) == 0) ? 0 : 12;
            rx_stall_max = ($urandom_range(0, 4) == 0) ? 0 : 12;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame(random_frame(), 41, -1);
            end else if (pick < 80) begin
                send_frame(random_frame(), 41, $urandom_range(0, 40));
            end else if (pick < 90) begin
                send_frame(random_frame(), $urandom_range(0, 40), -1);
            end else begin
                repeat ($urandom_range(1, 4)) send_beat(OP_EDGE, 16'($urandom));
            end
        end
    endtask

    initial begin
        in_bus.valid        = 1'b0;
        in_bus.operation    = OP_START;
        in_bus.pulse_length = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // disarmed edges, timeout boundary, restart while armed
        send_beat(OP_EDGE, 16'h0000);
        send_beat(OP_EDGE, 16'hFFFF);
        send_beat(OP_START, 16'hFFFF);
        send_beat(OP_EDGE, 16'd255);
        send_beat(OP_EDGE, 16'd256);
        send_beat(OP_EDGE, 16'd0);
        send_beat(OP_START, 16'h0000);
        send_beat(OP_EDGE, 16'd10);
        send_beat(OP_START, 16'h5555);
        send_beat(OP_EDGE, 16'hFFFF);

        send_frame(with_sum(32'h0000_0000), 41, -1);
        send_frame(with_sum(32'hFFFF_7FFF), 41, -1);
        send_frame(with_sum(32'h0292_8065), 41, -1);
        send_frame(with_sum(32'h0000_8000), 41, -1);
        send_frame(with_sum(32'h1234_FFFF), 41, -1);
        send_frame(40'hFF_FF_FF_FF_FF, 41, -1);
        send_frame(with_sum(32'h0155_00C8), 41, 40);

        // output held off while start/timeout pairs pile up
        quiesce();
        rx_hold    = 300;
        tx_gap_max = 0;
        repeat (40) begin
            send_beat(OP_START, 16'($urandom));
            send_beat(OP_EDGE, 16'hFFFF);
        end
        tx_gap_max = 12;

        set_config(1'b0, 0, 65535);
        random_frames(120);
        set_config(1'b0, 65535, 65535);
        random_frames(300);
        set_config(1'b1, 1, 0);
        send_frame(with_sum(32'h0), 41, -1);
        random_frames(120);
        while (useful_beats < 1900) begin
            if ($urandom_range(0, 4) == 0) begin
                set_config($urandom_range(0, 1), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            end else begin
                int thr;
                thr = $urandom_range(20, 150);
                set_config($urandom_range(0, 1), thr, thr + $urandom_range(1, 250));
            end
            random_frames(250);
        end

        quiesce();
        repeat (8) @(posedge i_clk);
        sb.close();
        if (sb.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
